[hdl/gav_pkg.sv]
package gav_pkg;

  // Configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_GOAL_X           = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GOAL_Y           = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ATTRACTION_GAIN  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROBOT_RADIUS     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ARRIVAL_DEADBAND = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TURN_BUMP        = 3'd5;

  localparam int CFG_DATA_W = 32;

  // Reset values
  localparam logic [30:0] GAIN_RST     = 31'd65536;
  localparam logic [30:0] RADIUS_RST   = 31'd65536;
  localparam logic [30:0] DEADBAND_RST = 31'd6554;
  localparam logic [30:0] BUMP_RST     = 31'd32768;

  // Taylor series constants for the quarter-wave table (unsigned Q30)
  localparam longint unsigned Q30_ONE    = 64'd1 << 30;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  // Configuration register file contents
  typedef struct packed {
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic [30:0]        attraction_gain;
    logic [30:0]        robot_radius;
    logic [30:0]        arrival_deadband;
    logic [30:0]        turn_bump;
  } cfg_t;

  // sin(r * 2pi / 2^bits) in Q15, evaluated at elaboration only
  function automatic logic [15:0] quarter_sine(input longint unsigned r,
                                               input int unsigned bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    x  = (r * TWO_PI_Q30) >> bits;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    s  = (s + (64'd1 << 14)) >> 15;
    if (s > 64'd32768) begin
      s = 64'd32768;
    end
    return s[15:0];
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

[hdl/gav_cfg_regs.sv]
module gav_cfg_regs
  import gav_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg_r
);

  cfg_t cfg_nxt;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_GOAL_X:           cfg_nxt.goal_x           = cfg_wdata;
        REG_GOAL_Y:           cfg_nxt.goal_y           = cfg_wdata;
        REG_ATTRACTION_GAIN:  cfg_nxt.attraction_gain  = cfg_wdata[30:0];
        REG_ROBOT_RADIUS:     cfg_nxt.robot_radius     = cfg_wdata[30:0];
        REG_ARRIVAL_DEADBAND: cfg_nxt.arrival_deadband = cfg_wdata[30:0];
        REG_TURN_BUMP:        cfg_nxt.turn_bump        = cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.goal_x           <= '0;
      cfg_r.goal_y           <= '0;
      cfg_r.attraction_gain  <= GAIN_RST;
      cfg_r.robot_radius     <= RADIUS_RST;
      cfg_r.arrival_deadband <= DEADBAND_RST;
      cfg_r.turn_bump        <= BUMP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[hdl/gav_sincos.sv]
module gav_sincos
  import gav_pkg::*;
#(
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] heading,
  output logic signed [16:0] sin_r,
  output logic signed [16:0] cos_r
);

  localparam int QUARTER = 1 << (TRIG_TABLE_BITS - 2);
  localparam int ROM_AW  = TRIG_TABLE_BITS - 1;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Quarter-wave table, one extra entry for the full quarter
  logic [15:0] rom [QUARTER+1];

  for (genvar i = 0; i <= QUARTER; i++) begin : g_rom
    assign rom[i] = quarter_sine(longint'(i), TRIG_TABLE_BITS);
  end

  logic [TRIG_TABLE_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [TRIG_TABLE_BITS-3:0] rem;
  logic [ROM_AW-1:0]          addr_a;
  logic [ROM_AW-1:0]          addr_b;
  logic signed [16:0]         a_val;
  logic signed [16:0]         b_val;
  logic signed [16:0]         sin_nxt;
  logic signed [16:0]         cos_nxt;

  assign idx    = heading[15 -: TRIG_TABLE_BITS];
  assign quad   = idx[TRIG_TABLE_BITS-1 -: 2];
  assign rem    = idx[TRIG_TABLE_BITS-3:0];
  assign addr_a = {1'b0, rem};
  assign addr_b = ROM_AW'(QUARTER) - {1'b0, rem};
  assign a_val  = $signed({1'b0, rom[addr_a]});
  assign b_val  = $signed({1'b0, rom[addr_b]});

  // Quadrant folding
  always_comb begin
    case (quad)
      QUAD_0: begin
        sin_nxt = a_val;
        cos_nxt = b_val;
      end
      QUAD_1: begin
        sin_nxt = b_val;
        cos_nxt = -a_val;
      end
      QUAD_2: begin
        sin_nxt = -a_val;
        cos_nxt = -b_val;
      end
      QUAD_3: begin
        sin_nxt = -b_val;
        cos_nxt = a_val;
      end
      default: begin
        sin_nxt = a_val;
        cos_nxt = b_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

endmodule

[hdl/gav_datapath.sv]
module gav_datapath
  import gav_pkg::*;
#(
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] robot_x,
  input  logic signed [31:0] robot_y,
  input  logic signed [15:0] heading,
  input  logic signed [31:0] requested_linear,
  input  logic signed [31:0] requested_angular,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] command_linear,
  output logic signed [31:0] command_angular,
  output logic               arrived
);

  localparam int NSTAGE = 7;

  // Per-stage valid and advance; a stage loads when empty or its successor loads
  logic [NSTAGE:1] v_r;
  logic [NSTAGE:1] v_nxt;
  logic [NSTAGE:1] en;

  always_comb begin
    en[NSTAGE] = !v_r[NSTAGE] || out_ready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[1] = en[1] ? in_valid : v_r[1];
    for (int k = 2; k <= NSTAGE; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v_r[NSTAGE];

  // Stage 1: goal offsets and sine/cosine lookup
  logic signed [32:0] dx_nxt, dy_nxt;
  logic signed [32:0] dx_r, dy_r;
  logic signed [31:0] rl1_r, ra1_r;
  logic signed [16:0] sn1_r, cs1_r;

  assign dx_nxt = {cfg.goal_x[31], cfg.goal_x} - {robot_x[31], robot_x};
  assign dy_nxt = {cfg.goal_y[31], cfg.goal_y} - {robot_y[31], robot_y};

  gav_sincos #(
    .TRIG_TABLE_BITS(TRIG_TABLE_BITS)
  ) u_sincos (
    .clk    (clk),
    .en     (en[1]),
    .heading(heading),
    .sin_r  (sn1_r),
    .cos_r  (cs1_r)
  );

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      rl1_r <= requested_linear;
      ra1_r <= requested_angular;
    end
  end

  // Stage 2: gain times offsets
  logic signed [31:0] gain_s;
  logic signed [64:0] gx_full, gy_full;
  logic signed [63:0] gx_r, gy_r;
  logic signed [31:0] rl2_r, ra2_r;
  logic signed [16:0] sn2_r, cs2_r;

  assign gain_s  = $signed({1'b0, cfg.attraction_gain});
  assign gx_full = gain_s * dx_r;
  assign gy_full = gain_s * dy_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      gx_r  <= gx_full[63:0];
      gy_r  <= gy_full[63:0];
      rl2_r <= rl1_r;
      ra2_r <= ra1_r;
      sn2_r <= sn1_r;
      cs2_r <= cs1_r;
    end
  end

  // Stage 3: saturate attraction terms, rotate by heading
  logic signed [31:0] vx, vy;
  logic signed [48:0] xs_nxt, yc_nxt, xc_nxt, ys_nxt;
  logic signed [48:0] xs_r, yc_r, xc_r, ys_r;
  logic signed [31:0] rl3_r, ra3_r;

  assign vx     = sat32(gy_r >>> 16);
  assign vy     = sat32(gx_r >>> 16);
  assign xs_nxt = vx * sn2_r;
  assign yc_nxt = vy * cs2_r;
  assign xc_nxt = vx * cs2_r;
  assign ys_nxt = vy * sn2_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      xs_r  <= xs_nxt;
      yc_r  <= yc_nxt;
      xc_r  <= xc_nxt;
      ys_r  <= ys_nxt;
      rl3_r <= rl2_r;
      ra3_r <= ra2_r;
    end
  end

  // Stage 4: linear sum, partial angular sum
  logic signed [49:0] lin_sum;
  logic signed [35:0] lin4_nxt, lin4_r;
  logic signed [33:0] p_nxt, p_r;
  logic signed [34:0] a1_nxt, a1_r;

  assign lin_sum  = {xs_r[48], xs_r} + {yc_r[48], yc_r};
  assign lin4_nxt = 36'(rl3_r) + 36'(lin_sum >>> 15);
  assign p_nxt    = 34'(ys_r >>> 15);
  assign a1_nxt   = 35'(ra3_r) + 35'(xc_r >>> 15);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      lin4_r <= lin4_nxt;
      p_r    <= p_nxt;
      a1_r   <= a1_nxt;
    end
  end

  // Stage 5: radius scaling
  logic signed [31:0] radius_s;
  logic signed [65:0] pr_full;
  logic signed [63:0] pr_r;
  logic signed [35:0] lin5_r;
  logic signed [34:0] a15_r;

  assign radius_s = $signed({1'b0, cfg.robot_radius});
  assign pr_full  = p_r * radius_s;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      pr_r   <= pr_full[63:0];
      lin5_r <= lin4_r;
      a15_r  <= a1_r;
    end
  end

  // Stage 6: angular total and deadband
  logic signed [48:0] ang_full;
  logic [35:0]        lin_mag;
  logic [48:0]        ang_mag;
  logic               lin_z, ang_z;
  logic signed [35:0] lin6_r;
  logic signed [48:0] ang6_r;
  logic               arr6_r;

  assign ang_full = 49'(a15_r) - 49'(pr_r >>> 16);
  assign lin_mag  = lin5_r[35] ? 36'(-lin5_r) : 36'(lin5_r);
  assign ang_mag  = ang_full[48] ? 49'(-ang_full) : 49'(ang_full);
  assign lin_z    = lin_mag < 36'(cfg.arrival_deadband);
  assign ang_z    = ang_mag < 49'(cfg.arrival_deadband);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      lin6_r <= lin_z ? '0 : lin5_r;
      ang6_r <= ang_z ? '0 : ang_full;
      arr6_r <= lin_z && ang_z;
    end
  end

  // Stage 7: reverse avoidance, bump and saturation into the output register
  logic               lin_le0, ang_le0;
  logic signed [31:0] bump_s;
  logic signed [49:0] ang_bumped;
  logic signed [31:0] lin_out_nxt, ang_out_nxt;

  assign lin_le0 = lin6_r[35] || (lin6_r == '0);
  assign ang_le0 = ang6_r[48] || (ang6_r == '0);
  assign bump_s  = $signed({1'b0, cfg.turn_bump});

  always_comb begin
    if (ang_le0) begin
      ang_bumped = 50'(ang6_r) - 50'(bump_s);
    end else begin
      ang_bumped = 50'(ang6_r) + 50'(bump_s);
    end
    if (lin_le0) begin
      lin_out_nxt = '0;
      ang_out_nxt = sat32(64'(ang_bumped));
    end else begin
      lin_out_nxt = sat32(64'(lin6_r));
      ang_out_nxt = sat32(64'(ang6_r));
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      command_linear  <= lin_out_nxt;
      command_angular <= ang_out_nxt;
      arrived         <= arr6_r;
    end
  end

endmodule

[hdl/goal_attraction_velocity_top.sv]
// Goal attraction velocity. Each input transaction carries a robot pose and a
// requested velocity; one result transaction follows with the commanded
// linear and angular velocity (signed Q16.16, saturated) and the arrived flag.
// The datapath is a seven-stage pipeline that takes one transaction every
// cycle while the output is not stalled. Stage boundaries follow the
// multipliers: gain by offset, the four heading rotation products, and the
// radius scaling each get a stage of their own. Backpressure holds each stage
// only while its successor is full, so empty stages keep filling during an
// output stall. The sine table holds 2^(TRIG_TABLE_BITS-2)+1 quarter-wave
// entries built at elaboration. Configuration writes are taken at any time
// but should only be issued while the pipeline is empty.
module goal_attraction_velocity_top
  import gav_pkg::*;
#(
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // robot_x[31:0], robot_y[63:32], heading[79:64],
  // requested_linear[111:80], requested_angular[143:112]
  input  logic [143:0]          in_tdata,
  // Result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // command_linear[31:0], command_angular[63:32]
  output logic [63:0]           out_tdata,
  // arrived[0]
  output logic                  out_tuser,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t               cfg;
  logic signed [31:0] command_linear;
  logic signed [31:0] command_angular;

  gav_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg_r    (cfg)
  );

  gav_datapath #(
    .TRIG_TABLE_BITS(TRIG_TABLE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_tvalid),
    .in_ready         (in_tready),
    .robot_x          ($signed(in_tdata[31:0])),
    .robot_y          ($signed(in_tdata[63:32])),
    .heading          ($signed(in_tdata[79:64])),
    .requested_linear ($signed(in_tdata[111:80])),
    .requested_angular($signed(in_tdata[143:112])),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .command_linear   (command_linear),
    .command_angular  (command_angular),
    .arrived          (out_tuser)
  );

  assign out_tdata = {command_angular, command_linear};

endmodule

[dv/tb_goal_attraction_velocity_top.sv]
module tb_goal_attraction_velocity_top
  import gav_pkg::*;
();

  localparam int TRIG_BITS       = 10;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASE_ITEMS     = 250;
  localparam int RX_HOLD_CYCLES  = 200;
  localparam int SETTLE_CYCLES   = 20;
  localparam longint unsigned QUARTER_STEPS = 64'd1 << (TRIG_BITS - 2);
  localparam longint unsigned Q30_UNIT      = 64'd1 << 30;
  localparam longint unsigned TWO_PI_Q30_TB = 64'd6746518852;

  // indexes outside the register map; writes there must be ignored
  localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE   = 32'h0001_0000;

  typedef struct {
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic signed [15:0] heading;
    logic signed [31:0] req_lin;
    logic signed [31:0] req_ang;
  } pose_t;

  typedef struct {
    logic signed [31:0] cmd_lin;
    logic signed [31:0] cmd_ang;
    logic               arrived;
  } velocity_cmd_t;

  // Scoreboard: velocity predictor plus queue of expected commands
  class velocity_scoreboard;
    longint        goal_x;
    longint        goal_y;
    longint        gain;
    longint        radius;
    longint        deadband;
    longint        bump;
    velocity_cmd_t expected_q[$];
    int            errors;

    function new();
      goal_x   = 0;
      goal_y   = 0;
      gain     = longint'(GAIN_RST);
      radius   = longint'(RADIUS_RST);
      deadband = longint'(DEADBAND_RST);
      bump     = longint'(BUMP_RST);
      errors   = 0;
    endfunction

    function void note_config(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
      logic signed [31:0] sdata;
      sdata = data;
      case (idx)
        REG_GOAL_X:           goal_x   = sdata;
        REG_GOAL_Y:           goal_y   = sdata;
        REG_ATTRACTION_GAIN:  gain     = longint'(data[30:0]);
        REG_ROBOT_RADIUS:     radius   = longint'(data[30:0]);
        REG_ARRIVAL_DEADBAND: deadband = longint'(data[30:0]);
        REG_TURN_BUMP:        bump     = longint'(data[30:0]);
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sh7FFF_FFFF) begin
        return 64'sh7FFF_FFFF;
      end else if (v < -64'sh8000_0000) begin
        return -64'sh8000_0000;
      end else begin
        return v;
      end
    endfunction

    // Q15 sine over the first quadrant; Horner form of the odd Taylor terms
    function longint quarter_wave(longint unsigned step);
      longint unsigned angle;
      longint unsigned sq;
      longint unsigned term;
      longint unsigned s;
      int unsigned     divs[5];
      divs  = '{110, 72, 42, 20, 6};
      angle = (step * TWO_PI_Q30_TB) >> TRIG_BITS;
      sq    = (angle * angle) >> 30;
      term  = Q30_UNIT;
      foreach (divs[k]) begin
        term = Q30_UNIT - ((sq * term) >> 30) / divs[k];
      end
      s = (angle * term) >> 30;
      s = (s + (64'd1 << 14)) >> 15;
      return (s > 64'd32768) ? 64'sd32768 : longint'(s);
    endfunction

    function velocity_cmd_t predict(pose_t p);
      longint                dx;
      longint                dy;
      longint                vx;
      longint                vy;
      longint                sn;
      longint                cs;
      longint                a;
      longint                b;
      longint                lin;
      longint                ang;
      longint                pr;
      logic [TRIG_BITS-1:0]  idx;
      logic [TRIG_BITS-3:0]  frac;
      bit                    lin_zero;
      bit                    ang_zero;
      velocity_cmd_t         res;
      dx = goal_x - longint'(p.robot_x);
      dy = goal_y - longint'(p.robot_y);
      vx = clamp32((gain * dy) >>> 16);
      vy = clamp32((gain * dx) >>> 16);

      // heading truncated to the table resolution, folded by quadrant
      idx  = p.heading[15 -: TRIG_BITS];
      frac = idx[TRIG_BITS-3:0];
      a    = quarter_wave(frac);
      b    = quarter_wave(QUARTER_STEPS - frac);
      case (idx[TRIG_BITS-1 -: 2])
        2'd0:    begin sn = a;  cs = b;  end
        2'd1:    begin sn = b;  cs = -a; end
        2'd2:    begin sn = -a; cs = -b; end
        default: begin sn = -b; cs = a;  end
      endcase

      lin = longint'(p.req_lin) + ((vx * sn + vy * cs) >>> 15);
      pr  = (vy * sn) >>> 15;
      ang = longint'(p.req_ang) + ((vx * cs) >>> 15) - ((pr * radius) >>> 16);

      // deadband on the wide values, then no reversing
      lin_zero = ((lin < 0) ? -lin : lin) < deadband;
      ang_zero = ((ang < 0) ? -ang : ang) < deadband;
      if (lin_zero) lin = 0;
      if (ang_zero) ang = 0;
      if (lin <= 0) begin
        lin = 0;
        ang = (ang <= 0) ? ang - bump : ang + bump;
      end

      res.cmd_lin = 32'(clamp32(lin));
      res.cmd_ang = 32'(clamp32(ang));
      res.arrived = lin_zero && ang_zero;
      return res;
    endfunction

    function void note_input(pose_t p);
      expected_q.insert(expected_q.size(), predict(p));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void check_result(velocity_cmd_t got);
      velocity_cmd_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transaction: lin %0d ang %0d arrived %0b",
                 $time, got.cmd_lin, got.cmd_ang, got.arrived);
        errors++;
      end else begin
        want = expected_q[0];
        expected_q.delete(0);
        if (got.cmd_lin !== want.cmd_lin) begin
          $display("%0t: command_linear expected %0d actual %0d",
                   $time, want.cmd_lin, got.cmd_lin);
          errors++;
        end
        if (got.cmd_ang !== want.cmd_ang) begin
          $display("%0t: command_angular expected %0d actual %0d",
                   $time, want.cmd_ang, got.cmd_ang);
          errors++;
        end
        if (got.arrived !== want.arrived) begin
          $display("%0t: arrived expected %0b actual %0b",
                   $time, want.arrived, got.arrived);
          errors++;
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [143:0]          in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [63:0]           out_tdata;
  logic                  out_tuser;
  logic                  cfg_we;
  logic [REG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  velocity_scoreboard board = new();

  // traffic shaping knobs, set by the stimulus process
  bit tx_quiet;
  bit rx_quiet;
  int rx_hold_req;

  goal_attraction_velocity_top #(
    .TRIG_TABLE_BITS(TRIG_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  // Result side: check accepted transactions, drive tready
  initial begin
    int            hold_left;
    velocity_cmd_t got;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.cmd_lin = out_tdata[31:0];
        got.cmd_ang = out_tdata[63:32];
        got.arrived = out_tuser;
        board.check_result(got);
      end
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (rx_quiet) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 13);
      end
    end
  end

  task automatic send_pose(input pose_t p);
    while (!tx_quiet && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p.req_ang, p.req_lin, p.heading, p.robot_y, p.robot_x};
    do @(posedge clk); while (!in_tready);
    board.note_input(p);
  endtask

  task automatic send_raw(input logic [31:0] x, input logic [31:0] y,
                          input logic [15:0] h, input logic [31:0] l,
                          input logic [31:0] a);
    pose_t p;
    p.robot_x = x;
    p.robot_y = y;
    p.heading = h;
    p.req_lin = l;
    p.req_ang = a;
    send_pose(p);
  endtask

  // stop offering and wait for every outstanding command
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    board.note_config(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int span(int bits);
    return int'($urandom_range(2 << bits)) - (1 << bits);
  endfunction

  // 31-bit register value: mostly moderate, sometimes an extreme; bit 31 is noise
  function automatic logic [31:0] draw_reg31(int unsigned typ_hi);
    logic [30:0] v;
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = '1;
      default: v = 31'($urandom_range(typ_hi));
    endcase
    return {1'($urandom_range(1)), v};
  endfunction

  // most poses land near the goal so deadband and bump paths get exercised
  function automatic pose_t random_pose();
    pose_t              p;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    int unsigned        pick;
    gx        = 32'(board.goal_x);
    gy        = 32'(board.goal_y);
    pick      = $urandom_range(99);
    p.heading = 16'($urandom());
    if (pick < 45) begin
      p.robot_x = gx + span(14);
      p.robot_y = gy + span(14);
      p.req_lin = span(14);
      p.req_ang = span(14);
    end else if (pick < 75) begin
      p.robot_x = gx + span(24);
      p.robot_y = gy + span(24);
      p.req_lin = span(22);
      p.req_ang = span(22);
    end else begin
      p.robot_x = $urandom();
      p.robot_y = $urandom();
      p.req_lin = $urandom();
      p.req_ang = $urandom();
    end
    return p;
  endfunction

  task automatic random_items(input int n);
    for (int i = 0; i < n; i++) begin
      send_pose(random_pose());
      if (i == n / 2) drain();
    end
  endtask

  task automatic randomize_config();
    write_reg(REG_GOAL_X, $urandom_range(1) ? 32'(span(20)) : 32'($urandom()));
    write_reg(REG_GOAL_Y, $urandom_range(1) ? 32'(span(20)) : 32'($urandom()));
    write_reg(REG_ATTRACTION_GAIN, draw_reg31(1 << 18));
    write_reg(REG_ROBOT_RADIUS, draw_reg31(1 << 18));
    write_reg(REG_ARRIVAL_DEADBAND, draw_reg31(1 << 15));
    write_reg(REG_TURN_BUMP, draw_reg31(1 << 17));
    write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom());
  endtask

  // Stimulus
  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_GOAL_X;
    cfg_wdata   <= '0;
    tx_quiet    = 1'b0;
    rx_quiet    = 1'b0;
    rx_hold_req = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: goal at origin, unit gain and radius
    send_raw(32'h0, 32'h0, 16'h0, 32'h0, 32'h0);            // exactly at goal
    send_raw(32'h0, 32'h0, 16'h0, 32'd100, -32'sd100);      // both in deadband
    send_raw(32'h0, 32'h0, 16'h0, 32'd6554, 32'd6554);      // deadband is strict
    send_raw(32'h0, 32'h0, 16'h0, 32'd6553, 32'd6554);      // linear only zeroed
    send_raw(32'h0, 32'h0, 16'h0, -Q_ONE, Q_ONE);           // reverse, turn positive
    send_raw(32'h0, 32'h0, 16'h0, -Q_ONE, -Q_ONE);          // reverse, turn negative
    send_raw(32'h0, S32_MIN, 16'h4000, S32_MAX, 32'h0);     // linear saturates high
    send_raw(S32_MAX, 32'h0, 16'h0, S32_MIN, S32_MIN);      // angular saturates low
    send_raw(32'h0, 32'h0, 16'h0, Q_ONE, S32_MAX);          // angular saturates high
    // heading sweep with a fixed offset from the goal
    send_raw(-Q_ONE, -(Q_ONE << 1), 16'h0000, 32'h0, 32'h0);
    send_raw(-Q_ONE, -(Q_ONE << 1), 16'h4000, 32'h0, 32'h0);
    send_raw(-Q_ONE, -(Q_ONE << 1), 16'h8000, 32'h0, 32'h0);
    send_raw(-Q_ONE, -(Q_ONE << 1), 16'hC000, 32'h0, 32'h0);
    send_raw(-Q_ONE, -(Q_ONE << 1), 16'h7FFF, 32'h0, 32'h0);
    send_raw(-Q_ONE, -(Q_ONE << 1), 16'h0040, 32'h0, 32'h0);
    send_raw(-Q_ONE, -(Q_ONE << 1), 16'h003F, 32'h0, 32'h0);
    send_raw(-Q_ONE, -(Q_ONE << 1), 16'hFFFF, 32'h0, 32'h0);
    send_raw(S32_MAX, S32_MIN, 16'h8000, 32'h0, 32'h0);
    send_raw(S32_MIN, S32_MAX, 16'h2000, 32'h0, 32'h0);
    drain();

    // extreme registers, upper bit of 31-bit registers set
    write_reg(REG_GOAL_X, S32_MIN);
    write_reg(REG_GOAL_Y, S32_MAX);
    write_reg(REG_ATTRACTION_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_ROBOT_RADIUS, 32'hFFFF_FFFF);
    write_reg(REG_ARRIVAL_DEADBAND, 32'h8000_0000);
    write_reg(REG_TURN_BUMP, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_A, $urandom());
    write_reg(REG_SPARE_B, $urandom());
    send_raw(S32_MAX, S32_MIN, 16'h0000, 32'h0, 32'h0);
    send_raw(S32_MIN, S32_MAX, 16'h0000, 32'h0, 32'h0);     // at goal, huge gain
    send_raw(S32_MAX, S32_MIN, 16'h4000, S32_MAX, S32_MAX);
    send_raw(S32_MAX, S32_MIN, 16'h8000, S32_MIN, S32_MIN);
    send_raw(32'h0, 32'h0, 16'h2000, 32'h0, 32'h0);
    random_items(200);
    drain();

    // no attraction, widest deadband, no bump
    write_reg(REG_ATTRACTION_GAIN, 32'h8000_0000);
    write_reg(REG_ROBOT_RADIUS, 32'h0);
    write_reg(REG_ARRIVAL_DEADBAND, 32'h7FFF_FFFF);
    write_reg(REG_TURN_BUMP, 32'h0);
    random_items(100);
    drain();

    // random configurations; one phase at full rate, one with a long output stall
    for (int phase = 0; phase < 6; phase++) begin
      randomize_config();
      tx_quiet = (phase == 2);
      rx_quiet = (phase == 2);
      if (phase == 4) rx_hold_req = RX_HOLD_CYCLES;
      random_items(PHASE_ITEMS);
      drain();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
hdl/gav_pkg.sv
hdl/gav_cfg_regs.sv
hdl/gav_sincos.sv
hdl/gav_datapath.sv
hdl/goal_attraction_velocity_top.sv
dv/tb_goal_attraction_velocity_top.sv
